// File: design/tas_pkg.sv
package tas_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int OP_W = 2;
    localparam int INDEX_W = 6;
    localparam int ACT_KIND_W = 3;
    localparam int SPEED_W = 8;
    localparam int DIR_W = 3;
    localparam int DUR_W = 8;
    localparam int COLOR_W = 24;
    localparam int SOUND_W = 8;
    localparam int MICROS_W = 20;
    localparam int LEN_CFG_W = 7;
    localparam int CMD_KIND_W = 4;
    localparam int CMD_VALUE_W = 24;
    localparam int TIMER_W = 32;
    localparam int THRESH_W = 25;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 24;

    localparam logic [16:0] TENTH_US = 17'd100000;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd100;
    localparam logic [7:0] LIGHT_ON_VALUE = 8'd255;
    localparam logic [DUR_W:0] MOTOR_TIMEOUT_PAD = 9'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [ACT_KIND_W-1:0] {
        ACT_DRIVE = 3'd0,
        ACT_HEAD  = 3'd1,
        ACT_TAIL  = 3'd2,
        ACT_UNDER = 3'd3,
        ACT_SOUND = 3'd4,
        ACT_DELAY = 3'd5
    } act_kind_t;

    typedef enum logic [CMD_KIND_W-1:0] {
        CMD_CLEAR     = 4'd0,
        CMD_SPEED     = 4'd1,
        CMD_DIRECTION = 4'd2,
        CMD_MOTOR_TO  = 4'd3,
        CMD_HEAD      = 4'd4,
        CMD_TAIL      = 4'd5,
        CMD_UNDER     = 4'd6,
        CMD_SOUND     = 4'd7,
        CMD_DONE      = 4'd8
    } cmd_kind_t;

    typedef enum logic [2:0] {
        VAL_ZERO,
        VAL_SPEED,
        VAL_DIR,
        VAL_MOTOR_TO,
        VAL_LIGHT,
        VAL_COLOR,
        VAL_SOUND
    } val_sel_t;

    typedef struct packed {
        logic [ACT_KIND_W-1:0] kind;
        logic [SPEED_W-1:0]    speed;
        logic [DIR_W-1:0]      dir;
        logic [DUR_W-1:0]      dur;
        logic                  on;
        logic [COLOR_W-1:0]    color;
        logic [SOUND_W-1:0]    sound;
    } act_entry_t;

    typedef struct packed {
        logic      load_entry;
        logic      start_play;
        logic      take_tick;
        logic      fetch;
        logic      accum;
        logic      start_action;
        logic      advance;
        logic      finish_action;
        logic      halt;
        logic      emit;
        cmd_kind_t emit_kind;
        val_sel_t  emit_val;
        logic      emit_last;
    } tas_cmd_t;

    typedef struct packed {
        logic                  running;
        logic                  at_end;
        logic                  started;
        logic                  expired;
        logic                  out_free;
        logic [ACT_KIND_W-1:0] act_kind;
    } tas_status_t;

endpackage

// File: design/timed_action_sequencer.sv
// Load, start and unknown items are handled while idle; the next item is accepted straight after.
// A tick is dropped when stopped, evaluates and checks a held action, and may end in stop and done.
// Results leave one per cycle from a single output register; a stalled result holds the controller.
// The action store is one memory with one registered read port, read once or twice per tick.
// Reset (aresetn low at a rising edge) clears the cursor, timer, flags, length and output valid.
// The action store is not cleared; entries are defined only once they have been loaded.
module timed_action_sequencer import tas_pkg::*; #(
    parameter int PROGRAM_DEPTH = DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // action_index, action_kind, drive_speed, drive_direction, duration_tenths,
    // light_on, light_color, sound_index, elapsed_micros, then zero padding.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation.
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  cfg_wr_en,
    input  logic [LEN_CFG_W-1:0]  cfg_wr_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // command_value.
    output logic [M_TDATA_W-1:0]  m_tdata,
    // command_kind.
    output logic [CMD_KIND_W-1:0] m_tuser,
    output logic                  m_tlast
);

    tas_cmd_t    cmd;
    tas_status_t status;

    tas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    tas_datapath #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// File: design/tas_datapath.sv
module tas_datapath import tas_pkg::*; #(
    parameter int PROGRAM_DEPTH = DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   cfg_wr_en,
    input  logic [LEN_CFG_W-1:0]   cfg_wr_data,
    input  tas_cmd_t               cmd,
    output tas_status_t            status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic [CMD_KIND_W-1:0]  m_tuser,
    output logic                   m_tlast
);

    localparam int AW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int CW = $clog2(PROGRAM_DEPTH + 1);
    localparam int LW = (CW > LEN_CFG_W) ? CW : LEN_CFG_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(PROGRAM_DEPTH);

    logic [INDEX_W-1:0]  in_index;
    logic [MICROS_W-1:0] in_micros;
    act_entry_t          in_entry;

    act_entry_t action_mem [PROGRAM_DEPTH];
    act_entry_t entry_reg;

    logic [LEN_CFG_W-1:0] program_length_reg;
    logic [CW-1:0]        cursor_reg;
    logic [CW-1:0]        cursor_next;
    logic [TIMER_W-1:0]   timer_reg;
    logic [TIMER_W-1:0]   timer_next;
    logic [THRESH_W-1:0]  thresh_reg;
    logic [MICROS_W-1:0]  micros_reg;
    logic                 started_reg;
    logic                 started_next;
    logic                 running_reg;
    logic                 running_next;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [CMD_KIND_W-1:0]  m_kind_reg;
    logic [M_TDATA_W-1:0]   m_value_reg;
    logic                   m_last_reg;

    logic [LW-1:0]      index_ext;
    logic [LW-1:0]      length_ext;
    logic [LW-1:0]      eff_len;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [TIMER_W:0]   timer_sum;
    logic [TIMER_W-1:0] timer_sat;
    logic [M_TDATA_W-1:0] emit_value;
    logic               out_free;

    assign in_index        = s_tdata[5:0];
    assign in_entry.kind   = s_tdata[8:6];
    assign in_entry.speed  = s_tdata[16:9];
    assign in_entry.dir    = s_tdata[19:17];
    assign in_entry.dur    = s_tdata[27:20];
    assign in_entry.on     = s_tdata[28];
    assign in_entry.color  = s_tdata[52:29];
    assign in_entry.sound  = s_tdata[60:53];
    assign in_micros       = s_tdata[80:61];

    assign index_ext  = LW'(in_index);
    assign length_ext = LW'(program_length_reg);
    assign eff_len    = (length_ext > DEPTH_L) ? DEPTH_L : length_ext;
    assign wr_addr    = index_ext[AW-1:0];
    assign rd_addr    = AW'(cursor_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_entry && (index_ext < DEPTH_L)) begin
            action_mem[wr_addr] <= in_entry;
        end
        if (cmd.fetch) begin
            entry_reg <= action_mem[rd_addr];
        end
    end

    assign timer_sum = {1'b0, timer_reg} + (TIMER_W + 1)'(micros_reg);
    assign timer_sat = timer_sum[TIMER_W] ? {TIMER_W{1'b1}} : timer_sum[TIMER_W-1:0];

    always_comb begin
        cursor_next  = cursor_reg;
        timer_next   = timer_reg;
        started_next = started_reg;
        running_next = running_reg;
        if (cmd.start_play) begin
            cursor_next  = '0;
            timer_next   = '0;
            started_next = 1'b0;
            running_next = 1'b1;
        end
        if (cmd.start_action) begin
            started_next = 1'b1;
            timer_next   = '0;
        end
        if (cmd.accum) begin
            timer_next = timer_sat;
        end
        if (cmd.advance) begin
            cursor_next = cursor_reg + CW'(1);
        end
        if (cmd.finish_action) begin
            cursor_next  = cursor_reg + CW'(1);
            timer_next   = '0;
            started_next = 1'b0;
        end
        if (cmd.halt) begin
            running_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            program_length_reg <= '0;
            cursor_reg         <= '0;
            timer_reg          <= '0;
            started_reg        <= 1'b0;
            running_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                program_length_reg <= cfg_wr_data;
            end
            cursor_reg  <= cursor_next;
            timer_reg   <= timer_next;
            started_reg <= started_next;
            running_reg <= running_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_tick) begin
            micros_reg <= in_micros;
        end
        if (cmd.accum) begin
            thresh_reg <= THRESH_W'(entry_reg.dur) * THRESH_W'(TENTH_US);
        end
    end

    always_comb begin
        case (cmd.emit_val)
            VAL_ZERO:     emit_value = '0;
            VAL_SPEED:    emit_value = M_TDATA_W'((entry_reg.speed > SPEED_MAX) ?
                                                  SPEED_MAX : entry_reg.speed);
            VAL_DIR:      emit_value = M_TDATA_W'(entry_reg.dir);
            VAL_MOTOR_TO: emit_value = M_TDATA_W'({1'b0, entry_reg.dur} + MOTOR_TIMEOUT_PAD);
            VAL_LIGHT:    emit_value = M_TDATA_W'(entry_reg.on ? LIGHT_ON_VALUE : 8'd0);
            VAL_COLOR:    emit_value = M_TDATA_W'(entry_reg.color);
            VAL_SOUND:    emit_value = M_TDATA_W'(entry_reg.sound);
            default:      emit_value = '0;
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_kind_reg  <= cmd.emit_kind;
            m_value_reg <= emit_value;
            m_last_reg  <= cmd.emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    assign status.running  = running_reg;
    assign status.at_end   = LW'(cursor_reg) >= eff_len;
    assign status.started  = started_reg;
    assign status.expired  = timer_reg >= TIMER_W'(thresh_reg);
    assign status.out_free = out_free;
    assign status.act_kind = entry_reg.kind;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("Result register loaded while a transfer is still pending.");

    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && (cmd.emit_kind == CMD_DONE)) |=> !running_reg)
        else $error("Playback still running after the done marker.");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        LW'(cursor_reg) <= DEPTH_L)
        else $error("Cursor beyond the program store.");

    a_accum_started: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accum |-> started_reg)
        else $error("Timer accumulated for an action that was never started.");
`endif

endmodule

// File: design/tas_ctrl.sv
module tas_ctrl import tas_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [OP_W-1:0]   s_tuser,
    input  tas_status_t       status,
    output tas_cmd_t          cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_NEXTRD,
        ST_NEXTCHK,
        ST_ADVCHK,
        ST_DRV0,
        ST_DRV1,
        ST_DRV2,
        ST_DRV3,
        ST_ONE,
        ST_STOP0,
        ST_STOP1,
        ST_STOP2,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_tuser)
                        OP_LOAD: begin
                            cmd.load_entry = 1'b1;
                        end
                        OP_START: begin
                            cmd.start_play = 1'b1;
                        end
                        OP_TICK: begin
                            if (status.running) begin
                                if (status.at_end) begin
                                    state_next = ST_DONE;
                                end else begin
                                    cmd.take_tick = 1'b1;
                                    cmd.fetch     = 1'b1;
                                    state_next    = ST_EVAL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVAL: begin
                if (status.started && ((status.act_kind == ACT_DRIVE) ||
                                       (status.act_kind == ACT_DELAY))) begin
                    cmd.accum  = 1'b1;
                    state_next = ST_CHECK;
                end else begin
                    case (status.act_kind)
                        ACT_DRIVE: begin
                            cmd.start_action = 1'b1;
                            state_next       = ST_DRV0;
                        end
                        ACT_HEAD, ACT_TAIL, ACT_UNDER, ACT_SOUND: begin
                            cmd.advance = 1'b1;
                            state_next  = ST_ONE;
                        end
                        ACT_DELAY: begin
                            cmd.start_action = 1'b1;
                            state_next       = ST_IDLE;
                        end
                        default: begin
                            cmd.advance = 1'b1;
                            state_next  = ST_ADVCHK;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (status.expired) begin
                    cmd.finish_action = 1'b1;
                    state_next = (status.act_kind == ACT_DRIVE) ? ST_NEXTRD : ST_ADVCHK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_NEXTRD: begin
                cmd.fetch  = 1'b1;
                state_next = ST_NEXTCHK;
            end
            ST_NEXTCHK: begin
                if (status.at_end || (status.act_kind != ACT_DRIVE)) begin
                    state_next = ST_STOP0;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADVCHK: begin
                state_next = status.at_end ? ST_DONE : ST_IDLE;
            end
            ST_DRV0: begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = CMD_CLEAR;
                cmd.emit_val  = VAL_ZERO;
                if (status.out_free) begin
                    state_next = ST_DRV1;
                end
            end
            ST_DRV1: begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = CMD_SPEED;
                cmd.emit_val  = VAL_SPEED;
                if (status.out_free) begin
                    state_next = ST_DRV2;
                end
            end
            ST_DRV2: begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = CMD_DIRECTION;
                cmd.emit_val  = VAL_DIR;
                if (status.out_free) begin
                    state_next = ST_DRV3;
                end
            end
            ST_DRV3: begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = CMD_MOTOR_TO;
                cmd.emit_val  = VAL_MOTOR_TO;
                cmd.emit_last = 1'b1;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ONE: begin
                cmd.emit      = status.out_free;
                cmd.emit_last = !status.at_end;
                case (status.act_kind)
                    ACT_HEAD: begin
                        cmd.emit_kind = CMD_HEAD;
                        cmd.emit_val  = VAL_LIGHT;
                    end
                    ACT_TAIL: begin
                        cmd.emit_kind = CMD_TAIL;
                        cmd.emit_val  = VAL_LIGHT;
                    end
                    ACT_UNDER: begin
                        cmd.emit_kind = CMD_UNDER;
                        cmd.emit_val  = VAL_COLOR;
                    end
                    default: begin
                        cmd.emit_kind = CMD_SOUND;
                        cmd.emit_val  = VAL_SOUND;
                    end
                endcase
                if (status.out_free) begin
                    state_next = status.at_end ? ST_DONE : ST_IDLE;
                end
            end
            ST_STOP0: begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = CMD_DIRECTION;
                cmd.emit_val  = VAL_ZERO;
                if (status.out_free) begin
                    state_next = ST_STOP1;
                end
            end
            ST_STOP1: begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = CMD_SPEED;
                cmd.emit_val  = VAL_ZERO;
                if (status.out_free) begin
                    state_next = ST_STOP2;
                end
            end
            ST_STOP2: begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = CMD_CLEAR;
                cmd.emit_val  = VAL_ZERO;
                cmd.emit_last = !status.at_end;
                if (status.out_free) begin
                    state_next = status.at_end ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = CMD_DONE;
                cmd.emit_val  = VAL_ZERO;
                cmd.emit_last = 1'b1;
                if (status.out_free) begin
                    cmd.halt   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
